// ----- src/n2a_pkg.sv -----
// Shared types, codes and helper functions for the number to ASCII formatter.
package n2a_pkg;

   localparam int ValueWidth = 32;
   localparam int DigitCount = 10;
   localparam int BcdWidth   = 4 * DigitCount;

   // Format selector codes
   localparam logic [1:0] OP_HEX_BYTE = 2'd0;
   localparam logic [1:0] OP_HEX_WORD = 2'd1;
   localparam logic [1:0] OP_DEC_BYTE = 2'd2;
   localparam logic [1:0] OP_DEC_WORD = 2'd3;

   // ASCII characters used by the formats
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_A    = 8'h61;

   // One classified job as it sits in the queue
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  is_hex;
      logic                  is_word;
   } job_type;

   // A job together with its valid flag
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_chan_type;

   // Map one nibble to a lowercase hex / decimal digit character
   function automatic logic [7:0] digit_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end else begin
         return CHAR_A + wide - 8'd10;
      end
   endfunction

   // One shift-and-add-3 step: add 3 to every BCD digit of 5 or more, then shift in a bit
   function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                      input logic bit_in);
      logic [BcdWidth-1:0] adj;
      adj = bcd;
      for (int k = 0; k < DigitCount; k++) begin
         if (bcd[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
         end
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction

endpackage

// ----- src/n2a_chan_if.sv -----
// Valid/ready channel interfaces for the formatter's request and response items.
interface n2a_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  operation;

   modport source (output valid, output value, output operation, input ready);
   modport sink   (input valid, input value, input operation, output ready);
endinterface

interface n2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/n2a_front.sv -----
// Front end: accepts request items, decodes the format and masks byte values.
module n2a_front (
   n2a_req_if.sink              req,
   input  logic                 q_full,
   output n2a_pkg::job_chan_type push
);
   import n2a_pkg::*;

   // Accept whenever the queue has room
   assign req.ready  = !q_full;

   // Classify the format and drop unused bits for byte formats
   always_comb begin
      push.valid       = req.valid && !q_full;
      push.job.value   = req.value;
      push.job.is_hex  = 1'b0;
      push.job.is_word = 1'b0;
      unique case (req.operation)
         OP_HEX_BYTE: begin
            push.job.value  = {24'd0, req.value[7:0]};
            push.job.is_hex = 1'b1;
         end
         OP_HEX_WORD: begin
            push.job.is_hex  = 1'b1;
            push.job.is_word = 1'b1;
         end
         OP_DEC_BYTE: begin
            push.job.value = {24'd0, req.value[7:0]};
         end
         OP_DEC_WORD: begin
            push.job.is_word = 1'b1;
         end
         default: begin
            push.job.is_hex = 1'b0;
         end
      endcase
   end

endmodule

// ----- src/n2a_queue.sv -----
// Two-entry job queue between the front and back ends.
module n2a_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  n2a_pkg::job_chan_type push,
   input  logic                  pop,
   output n2a_pkg::job_chan_type head,
   output logic                  full
);
   import n2a_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.job   = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue occupancy out of range");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && !push.valid) |=> (count_ff == 2'd0))
      else $error("queue filled without a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ----- src/n2a_back.sv -----
// Back end: binary to BCD conversion, leading zero skip and character output.
module n2a_back (
   input  logic                  clock,
   input  logic                  reset,
   input  n2a_pkg::job_chan_type head,
   output logic                  pop,
   n2a_rsp_if.source             rsp
);
   import n2a_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [BcdWidth-1:0] dig_ff, dig_in;
   logic [31:0]         bin_ff, bin_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [3:0]          ndig_ff, ndig_in;
   logic [1:0]          pre_ff, pre_in;
   logic                hex_ff, hex_in;
   logic                word_ff, word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic                out_free;
   logic                load_out;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

   assign pop      = (state_ff == ST_IDLE) && head.valid;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Sequence one job: load, convert, align, skip leading zeros, emit; hex jobs go from load to emit
   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      pre_in       = pre_ff;
      hex_in       = hex_ff;
      word_in      = word_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               hex_in  = head.job.is_hex;
               word_in = head.job.is_word;
               if (head.job.is_hex) begin
                  pre_in   = 2'd2;
                  ndig_in  = head.job.is_word ? 4'd8 : 4'd2;
                  dig_in   = head.job.is_word ? {head.job.value, 8'd0}
                                              : {head.job.value[7:0], 32'd0};
                  state_in = ST_EMIT;
               end else begin
                  pre_in   = 2'd0;
                  bin_in   = head.job.value;
                  dig_in   = '0;
                  cnt_in   = 5'd31;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in = dabble_step(dig_ff, bin_ff[31]);
            bin_in = {bin_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (word_ff) begin
               ndig_in  = 4'd10;
               state_in = ST_SKIP;
            end else begin
               dig_in   = {dig_ff[11:0], 28'd0};
               ndig_in  = 4'd3;
               state_in = ST_EMIT;
            end
         end
         ST_SKIP: begin
            // Drop leading zeros, keep at least one digit
            if (dig_ff[BcdWidth-1 -: 4] == 4'd0 && ndig_ff > 4'd1) begin
               dig_in  = {dig_ff[BcdWidth-5:0], 4'd0};
               ndig_in = ndig_ff - 4'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               if (pre_ff == 2'd2) begin
                  char_in = CHAR_ZERO;
                  last_in = 1'b0;
                  pre_in  = 2'd1;
               end else if (pre_ff == 2'd1) begin
                  char_in = CHAR_X;
                  last_in = 1'b0;
                  pre_in  = 2'd0;
               end else begin
                  char_in = digit_char(dig_ff[BcdWidth-1 -: 4]);
                  last_in = (ndig_ff == 4'd1);
                  dig_in  = {dig_ff[BcdWidth-5:0], 4'd0};
                  ndig_in = ndig_ff - 4'd1;
                  if (ndig_ff == 4'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pre_ff       <= 2'd0;
         ndig_ff      <= 4'd0;
         cnt_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pre_ff       <= pre_in;
         ndig_ff      <= ndig_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Hold datapath and output payload
   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      bin_ff  <= bin_in;
      hex_ff  <= hex_in;
      word_ff <= word_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

`ifndef NO_ASSERTIONS
   a_emit_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (ndig_ff != 4'd0 && ndig_ff <= 4'd10))
      else $error("digit count out of range while emitting");
   a_prefix_hex: assert property (@(posedge clock) disable iff (reset)
      (pre_ff != 2'd0) |-> hex_ff) else $error("hex prefix on a decimal job");
   a_conv_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV || state_ff == ST_FIX) |-> !hex_ff)
      else $error("hex job entered BCD conversion");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept running after the last character");
`endif

endmodule

// ----- src/number_to_ascii_formatter.sv -----
// Top level of the number to ASCII formatter.
//
// Takes one 32-bit value and a format code per request item and returns its
// ASCII text one character per response item, with last set on the final
// character. Formats: hex byte ("0x" and 2 digits), hex word ("0x" and 8
// digits), decimal byte (3 digits with leading zeros), decimal word (no
// leading zeros, a single '0' for zero). Hex items are loaded and then
// emitted one character at a time. Decimal items are loaded, run through
// shift-and-add-3 in the back end's BCD converter, aligned and then
// emitted; a word item also drops its leading zeros in a skip step before
// emitting. A receiver that holds a character off stalls the emit step.
// For decimal items the BCD converter sets the rate. A two-entry queue
// lets the front accept up to two more items while the back end works,
// and a registered output lets the back end start the next item while the
// last character of the previous one waits to be taken.
module number_to_ascii_formatter (
   input  logic      clock,
   input  logic      reset,
   n2a_req_if.sink   req_chan,
   n2a_rsp_if.source rsp_chan
);
   import n2a_pkg::*;

   job_chan_type push;
   job_chan_type head;
   logic         q_full;
   logic         pop;

   n2a_front u_front (
      .req    (req_chan),
      .q_full (q_full),
      .push   (push)
   );

   n2a_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   n2a_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the number to ASCII formatter: directed and random items.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import n2a_pkg::*;

   // One character of formatted text as it should leave the block
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   // One number waiting to be offered to the block
   typedef struct {
      logic [31:0] value;
      logic [1:0]  operation;
      bit          drain_first;
   } number_item_type;

   localparam int unsigned DrainCycles = 60;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned RandomItems = 300;

   logic clock;
   logic reset;

   n2a_req_if req_bus ();
   n2a_rsp_if rsp_bus ();

   number_item_type pending_items [$];
   text_char_type   expected_chars [$];

   int unsigned mismatch_count = 0;
   int unsigned items_accepted = 0;
   logic        req_accepted   = 1'b0;
   logic        rsp_accepted   = 1'b0;
   logic        rsp_hold       = 1'b0;

   number_to_ascii_formatter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Free-running clock, 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the text the block should emit for one number
   function automatic void predict_text(input logic [31:0] value, input logic [1:0] operation);
      logic [7:0]    text [$];
      logic [31:0]   number;
      logic [31:0]   divisor;
      logic [31:0]   digit;
      logic [3:0]    nib;
      logic [7:0]    ch;
      text_char_type entry;
      int            nibbles;
      int            i;
      bit            started;
      if (operation == OP_HEX_BYTE || operation == OP_HEX_WORD) begin
         nibbles = (operation == OP_HEX_BYTE) ? 2 : 8;
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_X);
         for (i = nibbles - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            ch  = (nib < 4'd10) ? CHAR_ZERO + {4'd0, nib} : CHAR_A + {4'd0, nib} - 8'd10;
            text.push_back(ch);
         end
      end else begin
         // Byte keeps leading zeros, word drops them but keeps the last digit
         number  = (operation == OP_DEC_BYTE) ? {24'd0, value[7:0]} : value;
         divisor = (operation == OP_DEC_BYTE) ? 32'd100 : 32'd1000000000;
         started = (operation == OP_DEC_BYTE);
         while (divisor != 0) begin
            digit  = number / divisor;
            number = number - digit * divisor;
            if (started || digit != 0 || divisor == 1) begin
               started = 1'b1;
               text.push_back(CHAR_ZERO + digit[7:0]);
            end
            divisor = divisor / 10;
         end
      end
      for (i = 0; i < text.size(); i++) begin
         entry.character = text[i];
         entry.last      = (i == text.size() - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   // Pick a random wait, or none during a quiet stretch
   function automatic int unsigned draw_wait(inout int unsigned stretch_left, inout bit quiet);
      if (stretch_left == 0) begin
         quiet        = ($urandom_range(0, 2) == 0);
         stretch_left = $urandom_range(8, 30);
      end
      stretch_left--;
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   // Record accepted numbers and predict their text
   always @(posedge clock) begin
      req_accepted <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_text(req_bus.value, req_bus.operation);
         items_accepted++;
      end
   end

   // Offer pending numbers with random gaps
   always @(negedge clock) begin
      static int unsigned gap_left     = 0;
      static int unsigned stretch_left = 0;
      static bit          quiet        = 1'b0;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.value     <= '0;
         req_bus.operation <= OP_HEX_BYTE;
      end else begin
         if (req_accepted) begin
            gap_left = draw_wait(stretch_left, quiet);
         end
         if (req_bus.valid && !req_accepted) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (pending_items.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (pending_items[0].drain_first && expected_chars.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.value     <= pending_items[0].value;
            req_bus.operation <= pending_items[0].operation;
            void'(pending_items.pop_front());
         end
      end
   end

   // Drive ready with random stalls and the long hold
   always @(negedge clock) begin
      static int unsigned stall_left   = 0;
      static int unsigned stretch_left = 0;
      static bit          quiet        = 1'b0;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_accepted) begin
            stall_left = draw_wait(stretch_left, quiet);
         end
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Check each character against the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      text_char_type got;
      rsp_accepted <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.character = rsp_bus.character;
         got.last      = rsp_bus.last;
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected character %h last %b", got.character, got.last);
            end
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected character %h last %b, got character %h last %b",
                           want.character, want.last, got.character, got.last);
               end
            end
         end
      end
   end

   // Hold the receiver off twice so the block fills up and stalls its input
   initial begin
      int h;
      for (h = 0; h < 2; h++) begin
         while (items_accepted < ((h == 0) ? 60 : 200)) @(negedge clock);
         rsp_hold <= 1'b1;
         repeat (HoldCycles) @(negedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Build the stimulus, run reset and wait for the text to drain
   initial begin
      number_item_type item;
      logic [31:0]     power;
      int              n;
      int              k;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.value     = '0;
      req_bus.operation = OP_HEX_BYTE;
      rsp_bus.ready     = 1'b0;

      // Directed: field extremes, every format, wide values in byte formats
      item.drain_first = 1'b0;
      item.operation = OP_HEX_BYTE;
      item.value = 32'h0000_0000; pending_items.push_back(item);
      item.value = 32'hffff_ffff; pending_items.push_back(item);
      item.value = 32'h0000_00a5; pending_items.push_back(item);
      item.value = 32'habcd_ef5a; pending_items.push_back(item);
      item.operation = OP_HEX_WORD;
      item.value = 32'h0000_0000; pending_items.push_back(item);
      item.value = 32'hffff_ffff; pending_items.push_back(item);
      item.value = 32'h0123_4567; pending_items.push_back(item);
      item.value = 32'h89ab_cdef; pending_items.push_back(item);
      item.operation = OP_DEC_BYTE;
      item.value = 32'h0000_0000; pending_items.push_back(item);
      item.value = 32'h0000_00ff; pending_items.push_back(item);
      item.value = 32'hffff_ff07; pending_items.push_back(item);
      item.value = 32'd100;       pending_items.push_back(item);
      item.value = 32'd9;         pending_items.push_back(item);
      item.operation = OP_DEC_WORD;
      item.value = 32'd0;          pending_items.push_back(item);
      item.value = 32'd1;          pending_items.push_back(item);
      item.value = 32'd9;          pending_items.push_back(item);
      item.value = 32'd10;         pending_items.push_back(item);
      item.value = 32'hffff_ffff;  pending_items.push_back(item);
      item.value = 32'd1000000000; pending_items.push_back(item);
      item.value = 32'd999999999;  pending_items.push_back(item);
      item.value = 32'h8000_0000;  pending_items.push_back(item);

      // Random: full-range, small, single-bit and near powers of ten
      for (n = 0; n < RandomItems; n++) begin
         item.drain_first = (n == 0 || n == 150);
         item.operation   = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: item.value = $urandom;
            1: item.value = $urandom_range(0, 999);
            2: item.value = 32'd1 << $urandom_range(0, 31);
            default: begin
               power = 32'd1;
               for (k = $urandom_range(0, 9); k > 0; k--) begin
                  power = power * 10;
               end
               item.value = power * $urandom_range(1, 4) - $urandom_range(0, 1);
            end
         endcase
         pending_items.push_back(item);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_bus.valid) @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("** number_to_ascii_formatter: PASSED **");
      end else begin
         $display("** number_to_ascii_formatter: FAILED **");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("** number_to_ascii_formatter: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
src/n2a_pkg.sv
src/n2a_chan_if.sv
src/n2a_front.sv
src/n2a_queue.sv
src/n2a_back.sv
src/number_to_ascii_formatter.sv
test/tb_top.sv
